[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TRT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TRT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/trt_pkg.sv]
// ----------------------------------------------------------------------------
// trt_pkg
// Types and constants of the receive reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package trt_pkg;

  localparam int SEQ_W = 32;
  localparam int CNT_W = 17;
  localparam int LEN_W = 11;
  localparam int ST_W  = 3;

  localparam logic [CNT_W-1:0] BUF_RESET = CNT_W'(50 * 1024);
  localparam logic [SEQ_W-1:0] SEQ_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [ST_W-1:0] {
    ST_INORDER    = 3'd0,
    ST_STORED     = 3'd1,
    ST_OLD        = 3'd2,
    ST_MALFORMED  = 3'd3,
    ST_DROPPED    = 3'd4,
    ST_READ_DONE  = 3'd5,
    ST_READ_EMPTY = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CLS_FINAL,
    CLS_INORDER,
    CLS_OOO
  } cls_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EVAL,
    CMD_CLAMP,
    CMD_ADVANCE,
    CMD_ABSORB,
    CMD_GAIN,
    CMD_ACCUM,
    CMD_OFFSET,
    CMD_KEEP,
    CMD_STORE,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CLAMP,
    S_ADVANCE,
    S_ABSORB,
    S_GAIN,
    S_ACCUM,
    S_OFFSET,
    S_KEEP,
    S_STORE,
    S_EMIT
  } state_e;

  typedef struct packed {
    cls_e cls;
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[src/tcp_receive_reassembly_tracker.sv]
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_tracker
// Receive-side sequence tracker with an out-of-order interval table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries a segment arrival or an
// application read; every transfer yields exactly one result on the output
// channel (out_valid_o/out_ready_i). The buffer capacity is written through
// cfg_valid_i/cfg_ready_o, which is always ready; the user must write it only
// while the block is idle; the block does not enforce this. Reads and
// malformed, empty and old segments go from evaluation to the output;
// out-of-order segments pass offset, keep and store; in-order segments pass
// clamp, advance, absorb (k of 0..OOO_ENTRIES stored intervals, one per cycle),
// gain and accumulate. One item is in flight at a time; in_ready_o rises with out_valid_o.
// A held result sits in the output register while the next item is taken;
// that item's result waits until the register is free. Reset clears the
// expected number, the buffered count and all interval valid bits, and
// restores the capacity to 51200 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_receive_reassembly_tracker #(
  parameter int unsigned OOO_ENTRIES  = 8,
  parameter int unsigned MAX_PAYLOAD  = 1024,
  parameter int unsigned HEADER_BYTES = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [trt_pkg::CNT_W-1:0] buffer_bytes_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [trt_pkg::SEQ_W-1:0] seq_num_i,
  input  logic [trt_pkg::LEN_W-1:0] seg_len_i,
  input  logic [trt_pkg::LEN_W-1:0] frame_len_i,
  input  logic [trt_pkg::CNT_W-1:0] read_len_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [trt_pkg::SEQ_W-1:0] ack_num_o,
  output logic [trt_pkg::CNT_W-1:0] window_o,
  output logic [trt_pkg::CNT_W-1:0] read_granted_o,
  output logic [trt_pkg::ST_W-1:0]  status_o
);
  import trt_pkg::*;

  cmd_e       cmd;
  dp_status_t stat;

  assign cfg_ready_o = 1'b1;

  trt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  trt_dp #(
    .OOO_ENTRIES  (OOO_ENTRIES),
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .buffer_bytes_i (buffer_bytes_i),
    .req_type_i     (req_type_i),
    .seq_num_i      (seq_num_i),
    .seg_len_i      (seg_len_i),
    .frame_len_i    (frame_len_i),
    .read_len_i     (read_len_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ack_num_o      (ack_num_o),
    .window_o       (window_o),
    .read_granted_o (read_granted_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

[src/trt_ctrl.sv]
// ----------------------------------------------------------------------------
// trt_ctrl
// Sequencer that steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  trt_pkg::dp_status_t stat_i,
  output logic                in_ready_o,
  output trt_pkg::cmd_e       cmd_o
);
  import trt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat_i.cls)
          CLS_INORDER: state_d = S_CLAMP;
          CLS_OOO:     state_d = S_OFFSET;
          default:     state_d = S_EMIT;
        endcase
      end
      S_CLAMP:   state_d = S_ADVANCE;
      S_ADVANCE: state_d = S_ABSORB;
      S_ABSORB: begin
        if (!stat_i.hit) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN:    state_d = S_ACCUM;
      S_ACCUM:   state_d = S_EMIT;
      S_OFFSET:  state_d = S_KEEP;
      S_KEEP:    state_d = S_STORE;
      S_STORE:   state_d = S_EMIT;
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
        end
      end
      S_EVAL:    cmd_o = CMD_EVAL;
      S_CLAMP:   cmd_o = CMD_CLAMP;
      S_ADVANCE: cmd_o = CMD_ADVANCE;
      S_ABSORB:  cmd_o = CMD_ABSORB;
      S_GAIN:    cmd_o = CMD_GAIN;
      S_ACCUM:   cmd_o = CMD_ACCUM;
      S_OFFSET:  cmd_o = CMD_OFFSET;
      S_KEEP:    cmd_o = CMD_KEEP;
      S_STORE:   cmd_o = CMD_STORE;
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o = CMD_EMIT;
        end
      end
      default:   cmd_o = CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

[src/trt_dp.sv]
// ----------------------------------------------------------------------------
// trt_dp
// Sequence state, buffer count, interval table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trt_dp #(
  parameter int unsigned OOO_ENTRIES  = 8,
  parameter int unsigned MAX_PAYLOAD  = 1024,
  parameter int unsigned HEADER_BYTES = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trt_pkg::cmd_e               cmd_i,
  output trt_pkg::dp_status_t         stat_o,
  input  logic                        cfg_we_i,
  input  logic [trt_pkg::CNT_W-1:0]   buffer_bytes_i,
  input  logic                        req_type_i,
  input  logic [trt_pkg::SEQ_W-1:0]   seq_num_i,
  input  logic [trt_pkg::LEN_W-1:0]   seg_len_i,
  input  logic [trt_pkg::LEN_W-1:0]   frame_len_i,
  input  logic [trt_pkg::CNT_W-1:0]   read_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [trt_pkg::SEQ_W-1:0]   ack_num_o,
  output logic [trt_pkg::CNT_W-1:0]   window_o,
  output logic [trt_pkg::CNT_W-1:0]   read_granted_o,
  output logic [trt_pkg::ST_W-1:0]    status_o
);
  import trt_pkg::*;

  localparam int IDX_W = (OOO_ENTRIES > 1) ? $clog2(OOO_ENTRIES) : 1;
  localparam int HDR_W = LEN_W + 1;
  localparam int WID_W = SEQ_W + 1;
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PAYLOAD);
  localparam logic [HDR_W-1:0] HDR_LEN = HDR_W'(HEADER_BYTES);

  logic [CNT_W-1:0] bytes_q;
  logic [SEQ_W-1:0] ne_q;
  logic [CNT_W-1:0] buf_q;
  logic [OOO_ENTRIES-1:0] valid_q;
  logic             out_valid_q;

  logic             type_q;
  logic [SEQ_W-1:0] seq_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] frame_q;
  logic [CNT_W-1:0] rdlen_q;
  logic [WID_W-1:0] seg_end_q;
  logic [WID_W-1:0] tmp_q;
  logic [SEQ_W-1:0] old_q;
  logic [CNT_W-1:0] granted_q;
  status_e          status_q;

  logic [SEQ_W-1:0] start_q [OOO_ENTRIES];
  logic [SEQ_W-1:0] end_q   [OOO_ENTRIES];

  logic [SEQ_W-1:0] ack_q;
  logic [CNT_W-1:0] window_q;
  logic [CNT_W-1:0] ogranted_q;
  status_e          ostatus_q;

  logic [CNT_W-1:0] free_space;
  logic             malformed;
  logic             seq_le;
  logic             end_gt;
  logic             seq_gt;
  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic             any_free;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] granted_rd;
  logic [WID_W-1:0] adv_sum;
  logic [WID_W-1:0] acc_sum;
  logic [WID_W-1:0] store_sum;
  logic             store_ok;
  status_e          eval_status;
  cls_e             cls;

  assign free_space = (buf_q >= bytes_q) ? '0 : bytes_q - buf_q;
  assign malformed  = (CNT_W'(len_q) > MAX_LEN) ||
                      ((HDR_W'(len_q) + HDR_LEN) != HDR_W'(frame_q));
  assign seq_le     = (seq_q <= ne_q);
  assign end_gt     = (seg_end_q > WID_W'(ne_q));
  assign seq_gt     = (seq_q > ne_q);
  assign granted_rd = (rdlen_q < buf_q) ? rdlen_q : buf_q;
  assign room       = (WID_W'(bytes_q) > tmp_q) ? bytes_q - tmp_q[CNT_W-1:0] : '0;
  assign keep       = (CNT_W'(len_q) < room) ? CNT_W'(len_q) : room;
  assign adv_sum    = WID_W'(ne_q) + tmp_q;
  assign acc_sum    = WID_W'(buf_q) + tmp_q;
  assign store_sum  = WID_W'(seq_q) + WID_W'(tmp_q[CNT_W-1:0]);
  assign store_ok   = any_free && (tmp_q != '0);

  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = OOO_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (start_q[i] <= ne_q)) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cls = CLS_FINAL;
    if (type_q) begin
      eval_status = (buf_q == '0) ? ST_READ_EMPTY : ST_READ_DONE;
    end else if (malformed) begin
      eval_status = ST_MALFORMED;
    end else if (len_q == '0) begin
      eval_status = ST_OLD;
    end else if (seq_le && end_gt) begin
      eval_status = ST_INORDER;
      cls         = CLS_INORDER;
    end else if (seq_gt) begin
      eval_status = ST_STORED;
      cls         = CLS_OOO;
    end else begin
      eval_status = ST_OLD;
    end
  end

  assign stat_o.cls      = cls;
  assign stat_o.hit      = any_hit;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q     <= BUF_RESET;
      ne_q        <= '0;
      buf_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bytes_q <= buffer_bytes_i;
      end
      if (cmd_i == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_EVAL: begin
          if (type_q && (buf_q != '0)) begin
            buf_q <= buf_q - granted_rd;
          end
        end
        CMD_ADVANCE: begin
          ne_q <= adv_sum[SEQ_W] ? SEQ_MAX : adv_sum[SEQ_W-1:0];
        end
        CMD_ABSORB: begin
          if (any_hit) begin
            if (end_q[hit_idx] > ne_q) begin
              ne_q <= end_q[hit_idx];
            end
            valid_q[hit_idx] <= 1'b0;
          end
        end
        CMD_ACCUM: begin
          buf_q <= (acc_sum > WID_W'(CNT_MAX)) ? CNT_MAX : acc_sum[CNT_W-1:0];
        end
        CMD_STORE: begin
          if (store_ok) begin
            valid_q[free_idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        type_q    <= req_type_i;
        seq_q     <= seq_num_i;
        len_q     <= seg_len_i;
        frame_q   <= frame_len_i;
        rdlen_q   <= read_len_i;
        seg_end_q <= WID_W'(seq_num_i) + WID_W'(seg_len_i);
      end
      CMD_EVAL: begin
        old_q     <= ne_q;
        status_q  <= eval_status;
        granted_q <= (type_q && (buf_q != '0)) ? granted_rd : '0;
        tmp_q     <= seq_gt ? WID_W'(seq_q) - WID_W'(ne_q) : seg_end_q - WID_W'(ne_q);
      end
      CMD_CLAMP: begin
        if (tmp_q > WID_W'(free_space)) begin
          tmp_q <= WID_W'(free_space);
        end
      end
      CMD_GAIN: begin
        tmp_q <= WID_W'(ne_q - old_q);
      end
      CMD_OFFSET: begin
        tmp_q <= tmp_q + WID_W'(buf_q);
      end
      CMD_KEEP: begin
        tmp_q <= WID_W'(keep);
      end
      CMD_STORE: begin
        if (store_ok) begin
          start_q[free_idx] <= seq_q;
          end_q[free_idx]   <= store_sum[SEQ_W] ? SEQ_MAX : store_sum[SEQ_W-1:0];
        end else begin
          status_q <= ST_DROPPED;
        end
      end
      CMD_EMIT: begin
        ack_q      <= ne_q;
        window_q   <= free_space;
        ogranted_q <= granted_q;
        ostatus_q  <= status_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign ack_num_o      = ack_q;
  assign window_o       = window_q;
  assign read_granted_o = ogranted_q;
  assign status_o       = ostatus_q;

endmodule

`default_nettype wire

[src/trt_checker.sv]
// ----------------------------------------------------------------------------
// trt_checker
// Port-level checks of the reassembly tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trt_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic                      cfg_ready_o,
  input  wire logic [trt_pkg::CNT_W-1:0] buffer_bytes_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_o,
  input  wire logic                      req_type_i,
  input  wire logic [trt_pkg::SEQ_W-1:0] seq_num_i,
  input  wire logic [trt_pkg::LEN_W-1:0] seg_len_i,
  input  wire logic [trt_pkg::LEN_W-1:0] frame_len_i,
  input  wire logic [trt_pkg::CNT_W-1:0] read_len_i,
  input  wire logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire logic [trt_pkg::SEQ_W-1:0] ack_num_o,
  input  wire logic [trt_pkg::CNT_W-1:0] window_o,
  input  wire logic [trt_pkg::CNT_W-1:0] read_granted_o,
  input  wire logic [trt_pkg::ST_W-1:0]  status_o
);
  import trt_pkg::*;

  `TRT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(ack_num_o) && $stable(window_o) && $stable(read_granted_o) && $stable(status_o), "result changed while stalled")
  `TRT_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second item taken while one is in work")
  `TRT_ASSERT_IMP(a_grant_on_read, out_valid_o && (read_granted_o != '0), status_o == ST_READ_DONE, "bytes granted on a non-read result")

endmodule

bind tcp_receive_reassembly_tracker trt_checker u_trt_checker (.*);

`default_nettype wire

[sim/tcp_receive_reassembly_tracker_tb.sv]
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_tracker_tb
// Feeds segment and read transfers through the valid/ready input channel and
// checks every result against a cycle-free model of the sequence tracker.
// Each item's result is predicted when it is queued and becomes due when the
// input transfer happens. The sender runs in random bursts, the receiver
// stalls on its own pattern, and the buffer capacity changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_receive_reassembly_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trt_pkg::*;

  localparam int unsigned IVL_SLOTS    = 8;
  localparam int unsigned MAX_SEG      = 1024;
  localparam int unsigned HDR_BYTES    = 9;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned CAP_PLAN [9] = '{65536, 1024, 0, 3000, 0, 65536, 1024, 0, 0};

  typedef struct packed {
    logic             rd;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] seg_len;
    logic [LEN_W-1:0] frame_len;
    logic [CNT_W-1:0] read_len;
  } rx_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] ack;
    logic [CNT_W-1:0] window;
    logic [CNT_W-1:0] granted;
    status_e          status;
  } ack_info_t;

  typedef struct {
    rx_req_t   req;
    ack_info_t ack;
  } rx_pair_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] buffer_bytes_i = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             req_type_i     = 1'b0;
  logic [SEQ_W-1:0] seq_num_i      = '0;
  logic [LEN_W-1:0] seg_len_i      = '0;
  logic [LEN_W-1:0] frame_len_i    = '0;
  logic [CNT_W-1:0] read_len_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [SEQ_W-1:0] ack_num_o;
  logic [CNT_W-1:0] window_o;
  logic [CNT_W-1:0] read_granted_o;
  logic [ST_W-1:0]  status_o;

  // Tracker model state
  logic [SEQ_W-1:0] rcv_next;
  logic [CNT_W-1:0] held_bytes;
  logic [CNT_W-1:0] buf_cap;
  logic [SEQ_W-1:0] ivl_lo [IVL_SLOTS];
  logic [SEQ_W-1:0] ivl_hi [IVL_SLOTS];
  bit               ivl_ok [IVL_SLOTS];

  rx_pair_t    req_backlog [$];
  ack_info_t   acks_due [$];
  ack_info_t   drv_ack;
  bit          drv_busy     = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned rsp_mode     = 0;
  int unsigned rsp_tick     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;

  tcp_receive_reassembly_tracker #(
    .OOO_ENTRIES (IVL_SLOTS),
    .MAX_PAYLOAD (MAX_SEG),
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .buffer_bytes_i(buffer_bytes_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .seq_num_i     (seq_num_i),
    .seg_len_i     (seg_len_i),
    .frame_len_i   (frame_len_i),
    .read_len_i    (read_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ack_num_o     (ack_num_o),
    .window_o      (window_o),
    .read_granted_o(read_granted_o),
    .status_o      (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] free_room();
    return (held_bytes >= buf_cap) ? '0 : buf_cap - held_bytes;
  endfunction

  function automatic void absorb_ready();
    int pass, k, pick;
    for (pass = 0; pass < IVL_SLOTS; pass++) begin
      pick = -1;
      for (k = 0; k < IVL_SLOTS; k++) begin
        if (ivl_ok[k] && ivl_lo[k] <= rcv_next && (pick < 0 || ivl_lo[k] < ivl_lo[pick]))
          pick = k;
      end
      if (pick < 0) return;
      if (ivl_hi[pick] > rcv_next) rcv_next = ivl_hi[pick];
      ivl_ok[pick] = 1'b0;
    end
  endfunction

  function automatic ack_info_t rx_track(rx_req_t r);
    ack_info_t       a;
    longint unsigned seg_end, adv, grown, offset, room, keep, fill;
    logic [SEQ_W-1:0] prev;
    int              slot, k;
    a.granted = '0;
    if (r.rd) begin
      if (held_bytes == 0) begin
        a.status = ST_READ_EMPTY;
      end else begin
        a.granted  = (r.read_len < held_bytes) ? r.read_len : held_bytes;
        held_bytes = held_bytes - a.granted;
        a.status   = ST_READ_DONE;
      end
    end else begin
      seg_end = r.seq;
      seg_end += r.seg_len;
      if (r.seg_len > MAX_SEG || r.seg_len + HDR_BYTES != r.frame_len) begin
        a.status = ST_MALFORMED;
      end else if (r.seg_len == 0) begin
        a.status = ST_OLD;
      end else if (r.seq <= rcv_next && seg_end > rcv_next) begin
        prev = rcv_next;
        adv  = seg_end - rcv_next;
        if (adv > free_room()) adv = free_room();
        fill = rcv_next;
        fill += adv;
        rcv_next = (fill > SEQ_MAX) ? SEQ_MAX : fill[SEQ_W-1:0];
        absorb_ready();
        grown = held_bytes;
        grown += rcv_next - prev;
        held_bytes = (grown > CNT_MAX) ? CNT_MAX : grown[CNT_W-1:0];
        a.status   = ST_INORDER;
      end else if (r.seq > rcv_next) begin
        offset = r.seq;
        offset = offset - rcv_next + held_bytes;
        room   = (buf_cap > offset) ? buf_cap - offset : 0;
        keep   = (r.seg_len < room) ? r.seg_len : room;
        slot   = -1;
        for (k = IVL_SLOTS - 1; k >= 0; k--) begin
          if (!ivl_ok[k]) slot = k;
        end
        if (keep == 0 || slot < 0) begin
          a.status = ST_DROPPED;
        end else begin
          fill = r.seq;
          fill += keep;
          ivl_lo[slot] = r.seq;
          ivl_hi[slot] = (fill > SEQ_MAX) ? SEQ_MAX : fill[SEQ_W-1:0];
          ivl_ok[slot] = 1'b1;
          a.status     = ST_STORED;
        end
      end else begin
        a.status = ST_OLD;
      end
    end
    a.ack    = rcv_next;
    a.window = free_room();
    return a;
  endfunction

  function automatic rx_req_t seg_req(longint unsigned seq, int unsigned len);
    rx_req_t r;
    r.rd        = 1'b0;
    r.seq       = seq[SEQ_W-1:0];
    r.seg_len   = len;
    r.frame_len = len + HDR_BYTES;
    r.read_len  = $urandom;
    return r;
  endfunction

  function automatic rx_req_t read_req(int unsigned len);
    rx_req_t r;
    r.rd        = 1'b1;
    r.seq       = $urandom;
    r.seg_len   = $urandom;
    r.frame_len = $urandom;
    r.read_len  = len;
    return r;
  endfunction

  function automatic void queue_req(rx_req_t r);
    rx_pair_t p;
    p.req = r;
    p.ack = rx_track(r);
    req_backlog.push_back(p);
  endfunction

  function automatic rx_req_t random_req();
    int unsigned     pick, len, back;
    longint unsigned nx, slack;
    rx_req_t         r;
    pick = $urandom_range(0, 99);
    nx   = rcv_next;
    len  = $urandom_range(1, MAX_SEG);
    if (pick < 42) begin
      back = $urandom_range(0, len - 1);
      if (back > nx) back = nx;
      r = seg_req(nx - back, len);
    end else if (pick < 57) begin
      if ($urandom_range(0, 5) == 0) r = seg_req(nx + $urandom_range(1, 70000), len);
      else r = seg_req(nx + $urandom_range(1, 3000), len);
    end else if (pick < 82) begin
      case ($urandom_range(0, 7))
        0:       r = read_req(1 << 16);
        1:       r = read_req($urandom_range(0, 1 << 16));
        default: r = read_req($urandom_range(0, 2048));
      endcase
    end else if (pick < 87) begin
      if (nx >= len) begin
        slack = nx - len;
        if (slack > 5000) slack = 5000;
        r = seg_req(nx - len - $urandom_range(0, slack), len);
      end else begin
        r = seg_req(nx, 0);
      end
    end else if (pick < 92) begin
      r = seg_req($urandom, len);
      r.seg_len   = $urandom_range(0, 2047);
      r.frame_len = $urandom_range(0, 2047);
    end else if (pick < 96) begin
      r = seg_req($urandom, 0);
    end else begin
      r = seg_req($urandom, len);
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string why, ack_info_t want, ack_info_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch, %s: expected ack=%h win=%0d grant=%0d st=%0d",
               why, want.ack, want.window, want.granted, want.status,
               " got ack=%h win=%0d grant=%0d st=%0d",
               got.ack, got.window, got.granted, got.status);
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || drv_busy || acks_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    buffer_bytes_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    buf_cap = v;
  endtask

  // Sender: bursts of transfers separated by random gaps
  always @(posedge clk_i) begin
    rx_pair_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        acks_due.push_back(drv_ack);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_backlog.size() != 0) begin
          nxt      = req_backlog.pop_front();
          drv_ack  = nxt.ack;
          drv_busy = 1'b1;
          req_type_i  <= nxt.req.rd;
          seq_num_i   <= nxt.req.seq;
          seg_len_i   <= nxt.req.seg_len;
          frame_len_i <= nxt.req.frame_len;
          read_len_i  <= nxt.req.read_len;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap_left   = $urandom_range(0, 10);
          end
        end
      end
      in_valid_i <= drv_busy;
    end
  end

  // Receiver: free-running, short stalls or rare long stalls, mode changes periodically
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rsp_tick++;
      if (rsp_tick % 400 == 0) rsp_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        case (rsp_mode)
          1:       if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          2:       if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(8, 30);
          default: ;
        endcase
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    ack_info_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.ack     = ack_num_o;
      got.window  = window_o;
      got.granted = read_granted_o;
      got.status  = status_e'(status_o);
      if (acks_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = acks_due.pop_front();
        if (got.ack !== want.ack || got.window !== want.window ||
            got.granted !== want.granted || got.status !== want.status)
          flag_mismatch("field mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_req_t r;
    int      phase, n;
    rcv_next   = '0;
    held_bytes = '0;
    buf_cap    = BUF_RESET;
    for (n = 0; n < IVL_SLOTS; n++) ivl_ok[n] = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    queue_req(read_req(1 << 16));
    queue_req(seg_req(0, 0));
    r = seg_req(0, 100);
    r.frame_len = 100;
    queue_req(r);
    r = seg_req(0, 0);
    r.frame_len = 0;
    queue_req(r);
    r = seg_req(0, 0);
    r.seg_len   = MAX_SEG + 6;
    r.frame_len = MAX_SEG + 6 + HDR_BYTES;
    queue_req(r);
    r = seg_req(32'hFFFF_FFFF, 0);
    r.seg_len   = '1;
    r.frame_len = '1;
    queue_req(r);
    queue_req(seg_req(0, MAX_SEG));
    queue_req(seg_req(0, 500));
    queue_req(seg_req(2048, 100));
    queue_req(seg_req(1500, 600));
    queue_req(seg_req(1024, 500));
    queue_req(seg_req(2000, 300));
    queue_req(seg_req(rcv_next + 60000, 100));
    queue_req(seg_req(rcv_next + free_room() - 10, 100));
    for (n = 0; n < IVL_SLOTS; n++) queue_req(seg_req(rcv_next + 3000 + 200 * n, 50));
    queue_req(read_req(0));
    queue_req(read_req(1 << 16));
    queue_req(seg_req(32'hFFFF_FFFF, MAX_SEG));

    for (phase = 0; phase < $size(CAP_PLAN); phase++) begin
      wait_drained();
      write_cap((CAP_PLAN[phase] != 0) ? CAP_PLAN[phase] : $urandom_range(1024, 65536));
      for (n = 0; n < PHASE_ITEMS; n++) queue_req(random_req());
    end

    wait_drained();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
